/* src/tlecd_pkg.sv */
// ----------------------------------------------------------------------------
// Two-level event channel dispatch: shared definitions
// Field widths, operation codes, result limits and the controller state type.
// ----------------------------------------------------------------------------
package tlecd_pkg;

   localparam int KIND_W    = 3;
   localparam int PORT_W    = 5;
   localparam int VCPU_W    = 2;
   localparam int PRESENT_W = 4;

   // A poll never emits more results than this.
   localparam int MAX_RESULTS = 32;
   localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

   localparam logic [PRESENT_W-1:0] PRESENT_RESET = 4'hF;

   localparam logic [KIND_W-1:0] KIND_RAISE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACK    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_MASK   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_UNMASK = 3'd3;
   localparam logic [KIND_W-1:0] KIND_POLL   = 3'd4;
   localparam logic [KIND_W-1:0] KIND_TAKE   = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SCAN,
      ST_LOAD,
      ST_BITS
   } state_type;

endpackage

/* src/two_level_event_channel_dispatch_core.sv */
// ----------------------------------------------------------------------------
// Two-level event channel dispatch core
// Pending/mask words, per-vCPU selectors and upcall flags kept in two RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is issued by raising start with req_kind, req_port and
//   req_vcpu while busy is low. The core is then busy until the last result
//   of that transaction has been driven. Results appear on the rsp_ ports for
//   exactly one cycle each, marked by rsp_valid; the last one carries
//   rsp_last. The receiver cannot stall, so no result is ever held back.
//   The csr_ channel writes the vCPU presence mask; csr_ready is always high
//   and writes are expected only while the core is idle.
// Sequencing:
//   Raise, ack, mask, unmask, take-upcall and unused kinds first read both
//   state RAMs, then write back and register the result.
//   A new transaction can be accepted in the cycle the result is shown.
//   A poll scans the selector from the resume point, with a word RAM read per
//   flagged word visited and an emit loop that handles one port per cycle.
// Reset:
//   Synchronous reset returns the controller to idle and clears the per-entry
//   valid bits, so every word reads as nothing pending, all masked, and every
//   vCPU as empty selector, no upcall and resume at word zero.
// ----------------------------------------------------------------------------
module two_level_event_channel_dispatch_core #(
   parameter int WORD_BITS      = 8,
   parameter int SELECTOR_WORDS = 4,
   parameter int VCPUS          = 4
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             start,
   output logic                             busy,
   input  logic [tlecd_pkg::KIND_W-1:0]     req_kind,
   input  logic [tlecd_pkg::PORT_W-1:0]     req_port,
   input  logic [tlecd_pkg::VCPU_W-1:0]     req_vcpu,

   output logic                             rsp_valid,
   output logic [tlecd_pkg::PORT_W-1:0]     rsp_event_port,
   output logic                             rsp_port_valid,
   output logic                             rsp_flag,
   output logic                             rsp_last,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tlecd_pkg::PRESENT_W-1:0]  csr_data
);

   localparam int WA   = (SELECTOR_WORDS > 1) ? $clog2(SELECTOR_WORDS) : 1;
   localparam int VA   = (VCPUS > 1) ? $clog2(VCPUS) : 1;
   localparam int BA   = $clog2(WORD_BITS);
   localparam int WE_W = 2 * WORD_BITS;              // {pending, mask}
   localparam int VE_W = SELECTOR_WORDS + 1 + WA;    // {selector, upcall, resume}

   // The port number is only five bits wide, so splitting it into word and
   // bit is a small constant table.
   function automatic logic [tlecd_pkg::PORT_W-1:0] port_word(
      input logic [tlecd_pkg::PORT_W-1:0] p);
      logic [tlecd_pkg::PORT_W-1:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (p == tlecd_pkg::PORT_W'(i)) begin
            r = tlecd_pkg::PORT_W'(i / WORD_BITS);
         end
      end
      return r;
   endfunction

   function automatic logic [BA-1:0] port_bit(input logic [tlecd_pkg::PORT_W-1:0] p);
      logic [BA-1:0] r;
      r = '0;
      for (int i = 0; i < 32; i++) begin
         if (p == tlecd_pkg::PORT_W'(i)) begin
            r = BA'(i % WORD_BITS);
         end
      end
      return r;
   endfunction

   function automatic logic [BA-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BA-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) begin
            r = BA'(i);
         end
      end
      return r;
   endfunction

   // Controller state.
   tlecd_pkg::state_type state_ff, state_in;

   // Latched transaction.
   logic [tlecd_pkg::KIND_W-1:0]    kind_ff;
   logic [WA-1:0]                   waddr_ff;
   logic [BA-1:0]                   bidx_ff;
   logic                            port_ok_ff;
   logic [VA-1:0]                   vaddr_ff;
   logic                            vin_ff;
   logic [tlecd_pkg::VCPU_W-1:0]    vcpu_ff;

   logic [tlecd_pkg::PRESENT_W-1:0] vcpu_present_ff;

   // Word RAM: pending and mask bits of one port word per entry.
   logic [WE_W-1:0]           word_mem [SELECTOR_WORDS];
   logic [SELECTOR_WORDS-1:0] word_vld_ff;
   logic [WE_W-1:0]           word_q_ff;
   logic                      word_qv_ff;
   logic [WA-1:0]             word_rd_addr;
   logic                      word_we;
   logic [WE_W-1:0]           word_wr_data;

   // vCPU RAM: selector, upcall flag and resume point per vCPU.
   logic [VE_W-1:0]  vcpu_mem [VCPUS];
   logic [VCPUS-1:0] vcpu_vld_ff;
   logic [VE_W-1:0]  vcpu_q_ff;
   logic             vcpu_qv_ff;
   logic             vcpu_we;
   logic [VE_W-1:0]  vcpu_wr_data;

   // Poll scan state.
   logic [SELECTOR_WORDS-1:0]     sel_ff, sel_in;
   logic [WA-1:0]                 cur_ff, cur_in;
   logic                          upc_ff, upc_in;
   logic [WORD_BITS-1:0]          pm_ff, pm_in;
   logic [tlecd_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                          held_vld_ff, held_vld_in;
   logic [tlecd_pkg::PORT_W-1:0]  held_port_ff, held_port_in;

   // Result register.
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [tlecd_pkg::PORT_W-1:0] rsp_port_ff, rsp_port_in;
   logic                         rsp_pvld_ff, rsp_pvld_in;
   logic                         rsp_flag_ff, rsp_flag_in;
   logic                         rsp_last_ff, rsp_last_in;

   // Decoded views.
   logic                         accept;
   logic [tlecd_pkg::PORT_W-1:0] req_word;
   logic [WORD_BITS-1:0]         word_pend, word_mask, bit_mask;
   logic [SELECTOR_WORDS-1:0]    vcpu_sel, sel_bit;
   logic                         vcpu_upc, vcpu_ok, poll_go, cur_at_end;
   logic [WA-1:0]                vcpu_res, cur_next;
   logic [BA-1:0]                low_bit;
   logic [tlecd_pkg::PORT_W-1:0] scan_port;

   assign busy      = (state_ff != tlecd_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;
   assign req_word  = port_word(req_port);

   // An entry that was never written reads as its reset value.
   assign word_pend = word_qv_ff ? word_q_ff[WE_W-1:WORD_BITS] : '0;
   assign word_mask = word_qv_ff ? word_q_ff[WORD_BITS-1:0] : '1;
   assign vcpu_sel  = vcpu_qv_ff ? vcpu_q_ff[VE_W-1 -: SELECTOR_WORDS] : '0;
   assign vcpu_upc  = vcpu_qv_ff ? vcpu_q_ff[WA] : 1'b0;
   assign vcpu_res  = vcpu_qv_ff ? vcpu_q_ff[WA-1:0] : '0;

   assign bit_mask  = WORD_BITS'(1) << bidx_ff;
   assign sel_bit   = SELECTOR_WORDS'(1) << waddr_ff;
   assign vcpu_ok   = vin_ff && vcpu_present_ff[vcpu_ff];
   assign poll_go   = vcpu_ok && (vcpu_sel != '0);

   assign cur_at_end = (cur_ff == WA'(SELECTOR_WORDS - 1));
   assign cur_next   = cur_at_end ? '0 : WA'(cur_ff + 1'b1);
   assign low_bit    = lowest_set(pm_ff);
   assign scan_port  = tlecd_pkg::PORT_W'(32'(cur_ff) * WORD_BITS + 32'(low_bit));

   // The word RAM is addressed by the scan pointer in the scan state of a poll
   // and by the request port in every other state.
   assign word_rd_addr = (state_ff == tlecd_pkg::ST_SCAN) ? cur_ff : WA'(req_word);

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tlecd_pkg::ST_IDLE: begin
            if (start) begin
               state_in = tlecd_pkg::ST_EXEC;
            end
         end
         tlecd_pkg::ST_EXEC: begin
            if ((kind_ff == tlecd_pkg::KIND_POLL) && poll_go) begin
               state_in = tlecd_pkg::ST_SCAN;
            end else begin
               state_in = tlecd_pkg::ST_IDLE;
            end
         end
         tlecd_pkg::ST_SCAN: begin
            if (sel_ff == '0) begin
               state_in = tlecd_pkg::ST_IDLE;
            end else if (sel_ff[cur_ff]) begin
               state_in = tlecd_pkg::ST_LOAD;
            end
         end
         tlecd_pkg::ST_LOAD: begin
            state_in = tlecd_pkg::ST_BITS;
         end
         tlecd_pkg::ST_BITS: begin
            if (pm_ff == '0) begin
               state_in = tlecd_pkg::ST_SCAN;
            end
         end
         default: begin
            state_in = tlecd_pkg::ST_IDLE;
         end
      endcase
   end

   // Datapath control and results.
   always_comb begin
      word_we      = 1'b0;
      word_wr_data = {word_pend, word_mask};
      vcpu_we      = 1'b0;
      vcpu_wr_data = {vcpu_sel, vcpu_upc, vcpu_res};
      sel_in       = sel_ff;
      cur_in       = cur_ff;
      upc_in       = upc_ff;
      pm_in        = pm_ff;
      count_in     = count_ff;
      held_vld_in  = held_vld_ff;
      held_port_in = held_port_ff;
      rsp_valid_in = 1'b0;
      rsp_port_in  = '0;
      rsp_pvld_in  = 1'b0;
      rsp_flag_in  = 1'b0;
      rsp_last_in  = 1'b0;

      unique case (state_ff)
         tlecd_pkg::ST_EXEC: begin
            // Every kind except a poll that finds work answers right here.
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            unique case (kind_ff)
               tlecd_pkg::KIND_RAISE: begin
                  if (port_ok_ff) begin
                     word_we      = 1'b1;
                     word_wr_data = {word_pend | bit_mask, word_mask};
                     // An unmasked port also flags its word and the upcall.
                     if (((word_mask & bit_mask) == '0) && vin_ff) begin
                        vcpu_we      = 1'b1;
                        vcpu_wr_data = {vcpu_sel | sel_bit, 1'b1, vcpu_res};
                     end
                  end
               end
               tlecd_pkg::KIND_ACK: begin
                  if (port_ok_ff) begin
                     word_we      = 1'b1;
                     word_wr_data = {word_pend & ~bit_mask, word_mask};
                  end
               end
               tlecd_pkg::KIND_MASK: begin
                  if (port_ok_ff) begin
                     word_we      = 1'b1;
                     word_wr_data = {word_pend, word_mask | bit_mask};
                  end
               end
               tlecd_pkg::KIND_UNMASK: begin
                  if (port_ok_ff) begin
                     word_we      = 1'b1;
                     word_wr_data = {word_pend, word_mask & ~bit_mask};
                     rsp_flag_in  = word_pend[bidx_ff];
                  end
               end
               tlecd_pkg::KIND_POLL: begin
                  // The selector is taken into the scan registers; the vCPU
                  // entry is written back once the scan has ended.
                  if (poll_go) begin
                     rsp_valid_in = 1'b0;
                     rsp_last_in  = 1'b0;
                     sel_in       = vcpu_sel;
                     cur_in       = vcpu_res;
                     upc_in       = vcpu_upc;
                     count_in     = '0;
                     held_vld_in  = 1'b0;
                  end
               end
               tlecd_pkg::KIND_TAKE: begin
                  if (vcpu_ok) begin
                     rsp_flag_in  = vcpu_upc;
                     vcpu_we      = 1'b1;
                     vcpu_wr_data = {vcpu_sel, 1'b0, vcpu_res};
                  end
               end
               default: begin
               end
            endcase
         end
         tlecd_pkg::ST_SCAN: begin
            if (sel_ff == '0) begin
               // Scan finished: clear the selector, store the resume point
               // and release the held port as the last result.
               vcpu_we      = 1'b1;
               vcpu_wr_data = {{SELECTOR_WORDS{1'b0}}, upc_ff, cur_ff};
               rsp_valid_in = 1'b1;
               rsp_port_in  = held_vld_ff ? held_port_ff : '0;
               rsp_pvld_in  = held_vld_ff;
               rsp_last_in  = 1'b1;
               held_vld_in  = 1'b0;
            end else if (!sel_ff[cur_ff]) begin
               cur_in = cur_next;
            end
         end
         tlecd_pkg::ST_LOAD: begin
            pm_in          = word_pend & ~word_mask;
            sel_in[cur_ff] = 1'b0;
         end
         tlecd_pkg::ST_BITS: begin
            if (pm_ff != '0) begin
               pm_in = pm_ff & (pm_ff - 1'b1);
               if (count_ff < tlecd_pkg::COUNT_W'(tlecd_pkg::MAX_RESULTS)) begin
                  // One port is held back so that the final one can be
                  // marked as last when the scan ends.
                  count_in     = tlecd_pkg::COUNT_W'(count_ff + 1'b1);
                  held_vld_in  = 1'b1;
                  held_port_in = scan_port;
                  if (held_vld_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_port_in  = held_port_ff;
                     rsp_pvld_in  = 1'b1;
                  end
               end
            end else begin
               cur_in = cur_next;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= tlecd_pkg::ST_IDLE;
         word_vld_ff     <= '0;
         vcpu_vld_ff     <= '0;
         vcpu_present_ff <= tlecd_pkg::PRESENT_RESET;
         held_vld_ff     <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_vld_ff  <= held_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (word_we) begin
            word_vld_ff[waddr_ff] <= 1'b1;
         end
         if (vcpu_we) begin
            vcpu_vld_ff[vaddr_ff] <= 1'b1;
         end
         if (csr_valid) begin
            vcpu_present_ff <= csr_data;
         end
      end
   end

   // Word RAM with registered read port.
   always_ff @(posedge clock) begin
      if (word_we) begin
         word_mem[waddr_ff] <= word_wr_data;
      end
      word_q_ff  <= word_mem[word_rd_addr];
      word_qv_ff <= word_vld_ff[word_rd_addr];
   end

   // vCPU RAM with registered read port.
   always_ff @(posedge clock) begin
      if (vcpu_we) begin
         vcpu_mem[vaddr_ff] <= vcpu_wr_data;
      end
      vcpu_q_ff  <= vcpu_mem[VA'(req_vcpu)];
      vcpu_qv_ff <= vcpu_vld_ff[VA'(req_vcpu)];
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff    <= req_kind;
         waddr_ff   <= WA'(req_word);
         bidx_ff    <= port_bit(req_port);
         port_ok_ff <= (32'(req_word) < SELECTOR_WORDS);
         vaddr_ff   <= VA'(req_vcpu);
         vin_ff     <= (32'(req_vcpu) < VCPUS);
         vcpu_ff    <= req_vcpu;
      end
      sel_ff       <= sel_in;
      cur_ff       <= cur_in;
      upc_ff       <= upc_in;
      pm_ff        <= pm_in;
      count_ff     <= count_in;
      held_port_ff <= held_port_in;
      rsp_port_ff  <= rsp_port_in;
      rsp_pvld_ff  <= rsp_pvld_in;
      rsp_flag_ff  <= rsp_flag_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_port = rsp_port_ff;
   assign rsp_port_valid = rsp_pvld_ff;
   assign rsp_flag       = rsp_flag_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

/* src/tlecd_checker.sv */
// ----------------------------------------------------------------------------
// Two-level event channel dispatch: port checker
// Temporal checks on the dispatch core's ports, bound to the top level.
// ----------------------------------------------------------------------------
module tlecd_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_port_valid,
   input logic rsp_last
);

   // An accepted transaction keeps the core busy in the following cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not make the core busy");

   // Results only come out of work that was in progress.
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in progress");

   // More results are still coming after a non-final one.
   a_not_last_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("core went idle before the final result");

   // The final result frees the core for the next transaction.
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("core still busy after the final result");

   // A result without a dispatched port always stands alone.
   a_empty_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_port_valid |-> rsp_last)
      else $error("result without a port is not the final one");

endmodule

bind two_level_event_channel_dispatch_core tlecd_checker u_tlecd_checker (.*);
